>>> src/lqrbt_pkg.sv
// Shared types, constants and the microcode program of the LQR balance torque block.
// Depends on nothing; every other file of the block refers to it by scoped names.
package lqrbt_pkg;

  // Fixed field widths and fixed-point formats.
  localparam int DATA_W       = 32;
  localparam int DT_FRAC      = 24;
  localparam int DT_W         = DT_FRAC + 1;
  localparam int FRAC_DEF     = 16;
  localparam int INTEG_W_DEF  = 48;

  // Datapath widths: one signed 33x33 multiplier, a wide product accumulator for
  // integrator products taken in two halves, clamped terms and the torque sums.
  localparam int OPA_W        = DATA_W + 1;
  localparam int PROD_W       = 2 * OPA_W;
  localparam int EXT_W        = 64;
  localparam int WIDE_W       = PROD_W + DATA_W;
  localparam int TERM_LIM_BIT = 59;
  localparam int TERM_W       = TERM_LIM_BIT + 2;
  localparam int SUM_W        = EXT_W + 1;
  localparam int ACC_W        = 64;
  localparam int NEG_W        = ACC_W + 1;

  localparam logic [DATA_W-1:0] DT_ONE = DATA_W'(1) << DT_FRAC;

  localparam logic signed [WIDE_W-1:0] TERM_MAX = WIDE_W'(1) << TERM_LIM_BIT;
  localparam logic signed [WIDE_W-1:0] TERM_MIN = -TERM_MAX;

  localparam logic signed [NEG_W-1:0] SAT_MAX = NEG_W'(32'h7fff_ffff);
  localparam logic signed [NEG_W-1:0] SAT_MIN = -SAT_MAX - NEG_W'(1);

  // Gain registers, in configuration index order.
  localparam int GAIN_NUM   = 8;
  localparam int GAIN_IDX_W = $clog2(GAIN_NUM);

  typedef enum logic [GAIN_IDX_W-1:0] {
    GI_POS_INTEGRAL     = 3'd0,
    GI_POSITION         = 3'd1,
    GI_VELOCITY         = 3'd2,
    GI_TILT             = 3'd3,
    GI_TILT_RATE        = 3'd4,
    GI_HEADING_INTEGRAL = 3'd5,
    GI_HEADING          = 3'd6,
    GI_HEADING_RATE     = 3'd7
  } gain_idx_t;

  localparam logic signed [DATA_W-1:0] GAIN_RESET [GAIN_NUM] = '{
    -32'sd1465431, -32'sd3422369, -32'sd3263588, -32'sd10189695,
    -32'sd2807746, -32'sd46340951, -32'sd7996932, -32'sd687689
  };

  // One sensor sample as it enters the datapath.
  typedef struct packed {
    logic signed [DATA_W-1:0] pos_x;
    logic signed [DATA_W-1:0] vel_x;
    logic signed [DATA_W-1:0] pitch_angle;
    logic signed [DATA_W-1:0] yaw_angle;
    logic signed [DATA_W-1:0] pitch_rate;
    logic signed [DATA_W-1:0] yaw_rate;
    logic signed [DATA_W-1:0] reference_x;
    logic        [DATA_W-1:0] elapsed;
  } imu_item_t;

  // Control word fields.
  typedef enum logic [1:0] {
    SEQ_WAIT_IN,
    SEQ_NEXT,
    SEQ_DONE,
    SEQ_JUMP
  } seq_op_t;

  typedef enum logic [3:0] {
    MUL_NOP,
    MUL_ERR_DT,
    MUL_YAW_DT,
    MUL_POS,
    MUL_VEL,
    MUL_TILT,
    MUL_TILT_RATE,
    MUL_HEADING,
    MUL_HEADING_RATE,
    MUL_PSUM_LO,
    MUL_PSUM_HI,
    MUL_HSUM_LO,
    MUL_HSUM_HI,
    MUL_HNEG_LO,
    MUL_HNEG_HI
  } mul_op_t;

  typedef enum logic [1:0] {
    WIDE_NOP,
    WIDE_LOAD,
    WIDE_ADD_HI
  } wide_op_t;

  typedef enum logic [1:0] {
    TERM_NOP,
    TERM_DT,
    TERM_FRAC
  } term_op_t;

  typedef enum logic [2:0] {
    DST_NOP,
    DST_POS_SUM,
    DST_HEAD_SUM,
    DST_ACC_LOAD,
    DST_ACC_ADD,
    DST_LEFT,
    DST_RIGHT
  } dst_op_t;

  typedef struct packed {
    seq_op_t  seq;
    mul_op_t  mul;
    wide_op_t wide;
    term_op_t term;
    dst_op_t  dst;
  } ctrl_t;

  // Control word plus the handshake strobes, sequencer to datapath.
  typedef struct packed {
    ctrl_t word;
    logic  in_fire;
    logic  out_load;
  } seq_ctl_t;

  localparam int STEP_W   = 5;
  localparam int PROG_LEN = 19;
  localparam logic [STEP_W-1:0] STEP_START = '0;

  // The program. Each multiply enters the product register, then the wide
  // accumulator, then the clamped term register, and finally lands in its
  // destination. Integrator products take two multiplies (low half, then
  // high half).
  function automatic ctrl_t ucode(input logic [STEP_W-1:0] step);
    ctrl_t w;
    unique case (step)
      5'd0:    w = '{SEQ_WAIT_IN, MUL_NOP,          WIDE_NOP,    TERM_NOP,  DST_NOP};
      5'd1:    w = '{SEQ_NEXT,    MUL_ERR_DT,       WIDE_NOP,    TERM_NOP,  DST_NOP};
      5'd2:    w = '{SEQ_NEXT,    MUL_YAW_DT,       WIDE_LOAD,   TERM_NOP,  DST_NOP};
      5'd3:    w = '{SEQ_NEXT,    MUL_POS,          WIDE_LOAD,   TERM_DT,   DST_NOP};
      5'd4:    w = '{SEQ_NEXT,    MUL_VEL,          WIDE_LOAD,   TERM_DT,   DST_POS_SUM};
      5'd5:    w = '{SEQ_NEXT,    MUL_TILT,         WIDE_LOAD,   TERM_FRAC, DST_HEAD_SUM};
      5'd6:    w = '{SEQ_NEXT,    MUL_TILT_RATE,    WIDE_LOAD,   TERM_FRAC, DST_ACC_LOAD};
      5'd7:    w = '{SEQ_NEXT,    MUL_HEADING,      WIDE_LOAD,   TERM_FRAC, DST_ACC_ADD};
      5'd8:    w = '{SEQ_NEXT,    MUL_HEADING_RATE, WIDE_LOAD,   TERM_FRAC, DST_ACC_ADD};
      5'd9:    w = '{SEQ_NEXT,    MUL_PSUM_LO,      WIDE_LOAD,   TERM_FRAC, DST_ACC_ADD};
      5'd10:   w = '{SEQ_NEXT,    MUL_PSUM_HI,      WIDE_LOAD,   TERM_FRAC, DST_ACC_ADD};
      5'd11:   w = '{SEQ_NEXT,    MUL_HSUM_LO,      WIDE_ADD_HI, TERM_FRAC, DST_ACC_ADD};
      5'd12:   w = '{SEQ_NEXT,    MUL_HSUM_HI,      WIDE_LOAD,   TERM_FRAC, DST_NOP};
      5'd13:   w = '{SEQ_NEXT,    MUL_HNEG_LO,      WIDE_ADD_HI, TERM_NOP,  DST_ACC_ADD};
      5'd14:   w = '{SEQ_NEXT,    MUL_HNEG_HI,      WIDE_LOAD,   TERM_FRAC, DST_NOP};
      5'd15:   w = '{SEQ_NEXT,    MUL_NOP,          WIDE_ADD_HI, TERM_NOP,  DST_LEFT};
      5'd16:   w = '{SEQ_NEXT,    MUL_NOP,          WIDE_NOP,    TERM_FRAC, DST_NOP};
      5'd17:   w = '{SEQ_NEXT,    MUL_NOP,          WIDE_NOP,    TERM_NOP,  DST_RIGHT};
      5'd18:   w = '{SEQ_DONE,    MUL_NOP,          WIDE_NOP,    TERM_NOP,  DST_NOP};
      default: w = '{SEQ_JUMP,    MUL_NOP,          WIDE_NOP,    TERM_NOP,  DST_NOP};
    endcase
    return w;
  endfunction

  // Saturate a torque sum to the 32-bit output range.
  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [NEG_W-1:0] v);
    logic signed [NEG_W-1:0] c;
    if (v > SAT_MAX) begin
      c = SAT_MAX;
    end else if (v < SAT_MIN) begin
      c = SAT_MIN;
    end else begin
      c = v;
    end
    return DATA_W'(c);
  endfunction

endpackage

>>> src/lqrbt_imu_if.sv
// Input channel of the LQR balance torque block: one sensor sample per transfer.
// Depends on lqrbt_pkg for the field width.
interface lqrbt_imu_if;
  logic                                valid;
  logic                                ready;
  logic signed [lqrbt_pkg::DATA_W-1:0] pos_x;
  logic signed [lqrbt_pkg::DATA_W-1:0] vel_x;
  logic signed [lqrbt_pkg::DATA_W-1:0] pitch_angle;
  logic signed [lqrbt_pkg::DATA_W-1:0] yaw_angle;
  logic signed [lqrbt_pkg::DATA_W-1:0] pitch_rate;
  logic signed [lqrbt_pkg::DATA_W-1:0] yaw_rate;
  logic signed [lqrbt_pkg::DATA_W-1:0] reference_x;
  logic        [lqrbt_pkg::DATA_W-1:0] elapsed;

  modport source (
    output valid, pos_x, vel_x, pitch_angle, yaw_angle, pitch_rate, yaw_rate,
    output reference_x, elapsed,
    input  ready
  );

  modport sink (
    input  valid, pos_x, vel_x, pitch_angle, yaw_angle, pitch_rate, yaw_rate,
    input  reference_x, elapsed,
    output ready
  );
endinterface

>>> src/lqrbt_cmd_if.sv
// Output channel of the LQR balance torque block: one wheel torque pair per transfer.
// Depends on lqrbt_pkg for the field width.
interface lqrbt_cmd_if;
  logic                                valid;
  logic                                ready;
  logic signed [lqrbt_pkg::DATA_W-1:0] torque_left;
  logic signed [lqrbt_pkg::DATA_W-1:0] torque_right;

  modport source (
    output valid, torque_left, torque_right,
    input  ready
  );

  modport sink (
    input  valid, torque_left, torque_right,
    output ready
  );
endinterface

>>> src/lqrbt_sequencer.sv
// Step counter and program lookup of the LQR balance torque block, with the
// input and output handshakes. Depends on lqrbt_pkg for the program and types.
module lqrbt_sequencer (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  logic                   out_ready,
  output lqrbt_pkg::seq_ctl_t    ctl
);

  logic [lqrbt_pkg::STEP_W-1:0] step;
  logic [lqrbt_pkg::STEP_W-1:0] step_next;
  logic                         out_valid_next;
  lqrbt_pkg::ctrl_t             word;
  logic                         in_fire;
  logic                         out_free;
  logic                         out_load;

  // Fetch the control word of the current step.
  always_comb begin
    word = lqrbt_pkg::ucode(step);
  end

  // Handshake strobes: the wait step takes a transfer, the done step hands the
  // result to the output register once that register is free.
  always_comb begin
    in_ready = (word.seq == lqrbt_pkg::SEQ_WAIT_IN);
    in_fire  = in_ready && in_valid;
    out_free = !out_valid || out_ready;
    out_load = (word.seq == lqrbt_pkg::SEQ_DONE) && out_free;
    ctl      = '{word: word, in_fire: in_fire, out_load: out_load};
  end

  // Next step: advance, hold on a pending handshake, or jump back to the start.
  always_comb begin
    unique case (word.seq)
      lqrbt_pkg::SEQ_WAIT_IN: step_next = in_fire ? step + lqrbt_pkg::STEP_W'(1) : step;
      lqrbt_pkg::SEQ_NEXT:    step_next = step + lqrbt_pkg::STEP_W'(1);
      lqrbt_pkg::SEQ_DONE:    step_next = out_load ? lqrbt_pkg::STEP_START : step;
      lqrbt_pkg::SEQ_JUMP:    step_next = lqrbt_pkg::STEP_START;
      default:                step_next = lqrbt_pkg::STEP_START;
    endcase
  end

  // The output register stays full until its transfer completes.
  always_comb begin
    if (out_load) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step      <= lqrbt_pkg::STEP_START;
      out_valid <= 1'b0;
    end else begin
      step      <= step_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

>>> src/lqrbt_datapath.sv
// Datapath of the LQR balance torque block: gain registers, sample registers,
// the shared multiplier, term clamp, integrators and torque sums.
// Depends on lqrbt_pkg for widths, codes and the saturation helper.
module lqrbt_datapath #(
  parameter int FRAC_BITS        = lqrbt_pkg::FRAC_DEF,
  parameter int INTEGRATOR_WIDTH = lqrbt_pkg::INTEG_W_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    cfg_we,
  input  logic [lqrbt_pkg::GAIN_IDX_W-1:0]        cfg_index,
  input  logic [lqrbt_pkg::DATA_W-1:0]            cfg_data,
  input  lqrbt_pkg::imu_item_t                    item,
  input  lqrbt_pkg::seq_ctl_t                     ctl,
  output logic signed [lqrbt_pkg::DATA_W-1:0]     torque_left,
  output logic signed [lqrbt_pkg::DATA_W-1:0]     torque_right
);

  localparam int DW = lqrbt_pkg::DATA_W;
  localparam int SW = lqrbt_pkg::SUM_W;

  localparam logic signed [SW-1:0] INT_MAX = (SW'(1) << (INTEGRATOR_WIDTH - 1)) - SW'(1);
  localparam logic signed [SW-1:0] INT_MIN = -INT_MAX - SW'(1);

  // Configuration and sample registers.
  logic signed [DW-1:0]                     gain [lqrbt_pkg::GAIN_NUM];
  logic signed [lqrbt_pkg::OPA_W-1:0]       err;
  logic        [lqrbt_pkg::DT_W-1:0]        dt;
  logic signed [DW-1:0]                     px;
  logic signed [DW-1:0]                     vx;
  logic signed [DW-1:0]                     pitch;
  logic signed [DW-1:0]                     yaw;
  logic signed [DW-1:0]                     prate;
  logic signed [DW-1:0]                     yrate;

  // Pipeline registers and state.
  logic signed [lqrbt_pkg::PROD_W-1:0]      prod;
  logic signed [lqrbt_pkg::WIDE_W-1:0]      wide;
  logic signed [lqrbt_pkg::WIDE_W-1:0]      wide_next;
  logic signed [lqrbt_pkg::TERM_W-1:0]      term;
  logic signed [lqrbt_pkg::TERM_W-1:0]      term_next;
  logic signed [INTEGRATOR_WIDTH-1:0]       pos_sum;
  logic signed [INTEGRATOR_WIDTH-1:0]       head_sum;
  logic signed [lqrbt_pkg::ACC_W-1:0]       acc;
  logic signed [lqrbt_pkg::ACC_W-1:0]       left_acc;
  logic signed [lqrbt_pkg::ACC_W-1:0]       right_acc;

  // Combinational helpers.
  logic signed [lqrbt_pkg::OPA_W-1:0]       opa;
  logic signed [lqrbt_pkg::OPA_W-1:0]       opb;
  logic signed [lqrbt_pkg::OPA_W-1:0]       dt_op;
  logic signed [lqrbt_pkg::OPA_W-1:0]       heading_int_neg;
  logic signed [lqrbt_pkg::EXT_W-1:0]       pos_ext;
  logic signed [lqrbt_pkg::EXT_W-1:0]       head_ext;
  logic signed [lqrbt_pkg::WIDE_W-1:0]      shifted;
  logic signed [SW-1:0]                     integ_in;
  logic signed [SW-1:0]                     integ_sum;
  logic signed [SW-1:0]                     integ_sat;
  logic signed [lqrbt_pkg::ACC_W-1:0]       acc_sum;

  // Gain registers take configuration writes at any index of the list.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < lqrbt_pkg::GAIN_NUM; i++) begin
        gain[i] <= lqrbt_pkg::GAIN_RESET[i];
      end
    end else if (cfg_we) begin
      gain[cfg_index] <= cfg_data;
    end
  end

  // Capture a sample; a gap longer than one second counts as no time.
  always_ff @(posedge clk) begin
    if (ctl.in_fire) begin
      err   <= lqrbt_pkg::OPA_W'(item.pos_x) - lqrbt_pkg::OPA_W'(item.reference_x);
      dt    <= (item.elapsed > lqrbt_pkg::DT_ONE) ? '0 : item.elapsed[lqrbt_pkg::DT_W-1:0];
      px    <= item.pos_x;
      vx    <= item.vel_x;
      pitch <= item.pitch_angle;
      yaw   <= item.yaw_angle;
      prate <= item.pitch_rate;
      yrate <= item.yaw_rate;
    end
  end

  // Operand selection for the shared multiplier. Integrators enter as an
  // unsigned low half and a signed high half.
  always_comb begin
    dt_op           = signed'(lqrbt_pkg::OPA_W'(dt));
    heading_int_neg = -lqrbt_pkg::OPA_W'(gain[lqrbt_pkg::GI_HEADING_INTEGRAL]);
    pos_ext         = lqrbt_pkg::EXT_W'(pos_sum);
    head_ext        = lqrbt_pkg::EXT_W'(head_sum);
    unique case (ctl.word.mul)
      lqrbt_pkg::MUL_ERR_DT: begin
        opa = err;
        opb = dt_op;
      end
      lqrbt_pkg::MUL_YAW_DT: begin
        opa = lqrbt_pkg::OPA_W'(yaw);
        opb = dt_op;
      end
      lqrbt_pkg::MUL_POS: begin
        opa = lqrbt_pkg::OPA_W'(px);
        opb = lqrbt_pkg::OPA_W'(gain[lqrbt_pkg::GI_POSITION]);
      end
      lqrbt_pkg::MUL_VEL: begin
        opa = lqrbt_pkg::OPA_W'(vx);
        opb = lqrbt_pkg::OPA_W'(gain[lqrbt_pkg::GI_VELOCITY]);
      end
      lqrbt_pkg::MUL_TILT: begin
        opa = lqrbt_pkg::OPA_W'(pitch);
        opb = lqrbt_pkg::OPA_W'(gain[lqrbt_pkg::GI_TILT]);
      end
      lqrbt_pkg::MUL_TILT_RATE: begin
        opa = lqrbt_pkg::OPA_W'(prate);
        opb = lqrbt_pkg::OPA_W'(gain[lqrbt_pkg::GI_TILT_RATE]);
      end
      lqrbt_pkg::MUL_HEADING: begin
        opa = lqrbt_pkg::OPA_W'(yaw);
        opb = lqrbt_pkg::OPA_W'(gain[lqrbt_pkg::GI_HEADING]);
      end
      lqrbt_pkg::MUL_HEADING_RATE: begin
        opa = lqrbt_pkg::OPA_W'(yrate);
        opb = lqrbt_pkg::OPA_W'(gain[lqrbt_pkg::GI_HEADING_RATE]);
      end
      lqrbt_pkg::MUL_PSUM_LO: begin
        opa = signed'({1'b0, pos_ext[DW-1:0]});
        opb = lqrbt_pkg::OPA_W'(gain[lqrbt_pkg::GI_POS_INTEGRAL]);
      end
      lqrbt_pkg::MUL_PSUM_HI: begin
        opa = lqrbt_pkg::OPA_W'(signed'(pos_ext[lqrbt_pkg::EXT_W-1:DW]));
        opb = lqrbt_pkg::OPA_W'(gain[lqrbt_pkg::GI_POS_INTEGRAL]);
      end
      lqrbt_pkg::MUL_HSUM_LO: begin
        opa = signed'({1'b0, head_ext[DW-1:0]});
        opb = lqrbt_pkg::OPA_W'(gain[lqrbt_pkg::GI_HEADING_INTEGRAL]);
      end
      lqrbt_pkg::MUL_HSUM_HI: begin
        opa = lqrbt_pkg::OPA_W'(signed'(head_ext[lqrbt_pkg::EXT_W-1:DW]));
        opb = lqrbt_pkg::OPA_W'(gain[lqrbt_pkg::GI_HEADING_INTEGRAL]);
      end
      lqrbt_pkg::MUL_HNEG_LO: begin
        opa = signed'({1'b0, head_ext[DW-1:0]});
        opb = heading_int_neg;
      end
      lqrbt_pkg::MUL_HNEG_HI: begin
        opa = lqrbt_pkg::OPA_W'(signed'(head_ext[lqrbt_pkg::EXT_W-1:DW]));
        opb = heading_int_neg;
      end
      default: begin
        opa = '0;
        opb = '0;
      end
    endcase
  end

  // Multiplier stage.
  always_ff @(posedge clk) begin
    prod <= opa * opb;
  end

  // Wide accumulator: a plain product, or a high half added 32 places up.
  always_comb begin
    case (ctl.word.wide)
      lqrbt_pkg::WIDE_LOAD:   wide_next = lqrbt_pkg::WIDE_W'(prod);
      lqrbt_pkg::WIDE_ADD_HI: wide_next = wide + (lqrbt_pkg::WIDE_W'(prod) <<< DW);
      default:                wide_next = wide;
    endcase
  end

  always_ff @(posedge clk) begin
    wide <= wide_next;
  end

  // Term stage: floor shift down and clamp to the term limit.
  always_comb begin
    if (ctl.word.term == lqrbt_pkg::TERM_DT) begin
      shifted = wide >>> lqrbt_pkg::DT_FRAC;
    end else begin
      shifted = wide >>> FRAC_BITS;
    end
    if (ctl.word.term == lqrbt_pkg::TERM_NOP) begin
      term_next = term;
    end else if (shifted > lqrbt_pkg::TERM_MAX) begin
      term_next = lqrbt_pkg::TERM_W'(lqrbt_pkg::TERM_MAX);
    end else if (shifted < lqrbt_pkg::TERM_MIN) begin
      term_next = lqrbt_pkg::TERM_W'(lqrbt_pkg::TERM_MIN);
    end else begin
      term_next = lqrbt_pkg::TERM_W'(shifted);
    end
  end

  always_ff @(posedge clk) begin
    term <= term_next;
  end

  // One saturating adder serves both integrators.
  always_comb begin
    integ_in  = (ctl.word.dst == lqrbt_pkg::DST_HEAD_SUM) ? SW'(head_sum) : SW'(pos_sum);
    integ_sum = integ_in + SW'(term);
    if (integ_sum > INT_MAX) begin
      integ_sat = INT_MAX;
    end else if (integ_sum < INT_MIN) begin
      integ_sat = INT_MIN;
    end else begin
      integ_sat = integ_sum;
    end
    acc_sum = acc + lqrbt_pkg::ACC_W'(term);
  end

  // Integrator state.
  always_ff @(posedge clk) begin
    if (rst) begin
      pos_sum  <= '0;
      head_sum <= '0;
    end else if (ctl.word.dst == lqrbt_pkg::DST_POS_SUM) begin
      pos_sum  <= INTEGRATOR_WIDTH'(integ_sat);
    end else if (ctl.word.dst == lqrbt_pkg::DST_HEAD_SUM) begin
      head_sum <= INTEGRATOR_WIDTH'(integ_sat);
    end
  end

  // Torque sums: the common part, then each wheel with its own integral term.
  always_ff @(posedge clk) begin
    case (ctl.word.dst)
      lqrbt_pkg::DST_ACC_LOAD: acc       <= lqrbt_pkg::ACC_W'(term);
      lqrbt_pkg::DST_ACC_ADD:  acc       <= acc_sum;
      lqrbt_pkg::DST_LEFT:     left_acc  <= acc_sum;
      lqrbt_pkg::DST_RIGHT:    right_acc <= acc_sum;
      default: ;
    endcase
  end

  // Output register: negate and saturate both wheel sums.
  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      torque_left  <= lqrbt_pkg::sat32(-lqrbt_pkg::NEG_W'(left_acc));
      torque_right <= lqrbt_pkg::sat32(-lqrbt_pkg::NEG_W'(right_acc));
    end
  end

endmodule

>>> src/lqr_balance_torque.sv
// LQR balance and heading controller with integral action. For each sample a
// microcode program runs fourteen products through one shared 33x33
// multiplier, one product issued per step. A finished torque pair waits in an
// output register, so the next sample is taken as soon as the program restarts.
// Gains are written through cfg_we/cfg_index/cfg_data; the user must do so only
// while the block is idle, as the block itself does not enforce it.
// Depends on lqrbt_pkg, lqrbt_imu_if, lqrbt_cmd_if, lqrbt_sequencer, lqrbt_datapath.
module lqr_balance_torque #(
  parameter int FRAC_BITS        = lqrbt_pkg::FRAC_DEF,
  parameter int INTEGRATOR_WIDTH = lqrbt_pkg::INTEG_W_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [lqrbt_pkg::GAIN_IDX_W-1:0]   cfg_index,
  input  logic [lqrbt_pkg::DATA_W-1:0]       cfg_data,
  lqrbt_imu_if.sink                          imu,
  lqrbt_cmd_if.source                        cmd
);

  lqrbt_pkg::seq_ctl_t  ctl;
  lqrbt_pkg::imu_item_t item;
  logic                 in_ready;
  logic                 out_valid;

  // Pack the incoming sample for the datapath.
  always_comb begin
    item = '{
      pos_x:       imu.pos_x,
      vel_x:       imu.vel_x,
      pitch_angle: imu.pitch_angle,
      yaw_angle:   imu.yaw_angle,
      pitch_rate:  imu.pitch_rate,
      yaw_rate:    imu.yaw_rate,
      reference_x: imu.reference_x,
      elapsed:     imu.elapsed
    };
  end

  assign imu.ready = in_ready;
  assign cmd.valid = out_valid;

  lqrbt_sequencer u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (imu.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (cmd.ready),
    .ctl       (ctl)
  );

  lqrbt_datapath #(
    .FRAC_BITS        (FRAC_BITS),
    .INTEGRATOR_WIDTH (INTEGRATOR_WIDTH)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .item         (item),
    .ctl          (ctl),
    .torque_left  (cmd.torque_left),
    .torque_right (cmd.torque_right)
  );

  // Reset leaves the program waiting for a sample.
  a_reset_ready: assert property (@(posedge clk) rst |=> imu.ready)
    else $error("block not ready for a sample after reset");

  // After a sample transfer the program is busy on the next cycle.
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    ctl.in_fire |=> !imu.ready)
    else $error("sample taken while the previous one is still in work");

  // After a sample transfer the program runs on to its done step without a stall.
  a_program_length: assert property (@(posedge clk) disable iff (rst)
    ctl.in_fire |-> ##(lqrbt_pkg::PROG_LEN - 1) (ctl.word.seq == lqrbt_pkg::SEQ_DONE))
    else $error("microcode did not reach its done step on time");

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for lqr_balance_torque: drives IMU samples and gain writes,
// predicts every wheel torque pair and compares it with what the block returns.
// Depends on lqrbt_pkg, lqrbt_imu_if, lqrbt_cmd_if and the lqr_balance_torque RTL.
module tb_top;

  localparam int CYCLE_LIMIT   = 4000000;
  localparam int SETTLE_CYCLES = 40;
  localparam int FRAC          = lqrbt_pkg::FRAC_DEF;
  localparam int INTEG_W       = lqrbt_pkg::INTEG_W_DEF;
  localparam int DT_FRAC       = lqrbt_pkg::DT_FRAC;
  localparam int WINDUP_ITEMS  = 120;

  localparam logic [31:0]         DT_ONE     = lqrbt_pkg::DT_ONE;
  localparam logic signed [63:0]  INTEG_MAX  = (64'sd1 <<< (INTEG_W - 1)) - 64'sd1;
  localparam logic signed [63:0]  INTEG_MIN  = -INTEG_MAX - 64'sd1;
  localparam logic signed [127:0] TERM_BOUND = 128'sd1 <<< 59;
  localparam logic signed [31:0]  FIELD_MAX  = 32'sh7fff_ffff;
  localparam logic signed [31:0]  FIELD_MIN  = 32'sh8000_0000;

  typedef struct {
    logic signed [lqrbt_pkg::DATA_W-1:0] left;
    logic signed [lqrbt_pkg::DATA_W-1:0] right;
  } wheel_cmd_t;

  typedef logic signed [lqrbt_pkg::DATA_W-1:0] gain_set_t [lqrbt_pkg::GAIN_NUM];

  localparam gain_set_t POWER_ON_GAINS = '{
    -32'sd1465431, -32'sd3422369, -32'sd3263588, -32'sd10189695,
    -32'sd2807746, -32'sd46340951, -32'sd7996932, -32'sd687689
  };

  logic                             clk = 1'b0;
  logic                             rst;
  logic                             cfg_we;
  logic [lqrbt_pkg::GAIN_IDX_W-1:0] cfg_index;
  logic [lqrbt_pkg::DATA_W-1:0]     cfg_data;

  lqrbt_imu_if imu ();
  lqrbt_cmd_if cmd ();

  lqr_balance_torque dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .imu       (imu),
    .cmd       (cmd)
  );

  // Predictor state: gain registers and the two integrators.
  gain_set_t          gains = POWER_ON_GAINS;
  logic signed [63:0] pos_err_sum = '0;
  logic signed [63:0] head_err_sum = '0;

  wheel_cmd_t pending_cmds [$];
  int         failures = 0;
  int         cycle_count = 0;
  int         hold_cycles = 0;
  int         burst_left = 0;
  bit         steady_stream = 1'b0;

  // Clock, 8 ns period.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("lqr_balance_torque test failed");
      $finish;
    end
  end

  // floor(a * b / 2^sh), clamped to the term bound.
  function automatic logic signed [63:0] scaled_product(input logic signed [63:0] a,
                                                        input logic signed [63:0] b,
                                                        input int sh);
    logic signed [127:0] wa;
    logic signed [127:0] wb;
    logic signed [127:0] p;
    wa = a;
    wb = b;
    p = (wa * wb) >>> sh;
    if (p > TERM_BOUND) begin
      p = TERM_BOUND;
    end else if (p < -TERM_BOUND) begin
      p = -TERM_BOUND;
    end
    return p[63:0];
  endfunction

  // Integrator update with saturation at the integrator width.
  function automatic logic signed [63:0] sat_integrate(input logic signed [63:0] acc,
                                                       input logic signed [63:0] inc);
    logic signed [63:0] s;
    s = acc + inc;
    if (s > INTEG_MAX) begin
      s = INTEG_MAX;
    end else if (s < INTEG_MIN) begin
      s = INTEG_MIN;
    end
    return s;
  endfunction

  function automatic logic signed [lqrbt_pkg::DATA_W-1:0] clamp_torque(
      input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      return FIELD_MAX;
    end else if (v < -64'sd2147483648) begin
      return FIELD_MIN;
    end
    return v[lqrbt_pkg::DATA_W-1:0];
  endfunction

  // Advances the integrators by one sample and returns the torque pair it yields.
  function automatic wheel_cmd_t predict_cmd(input lqrbt_pkg::imu_item_t s);
    logic signed [63:0] px, vx, pitch, yaw, prate, yrate, refx, dt, g_hi;
    logic signed [63:0] balance, heading, left, right;
    wheel_cmd_t c;
    px    = $signed(s.pos_x);
    vx    = $signed(s.vel_x);
    pitch = $signed(s.pitch_angle);
    yaw   = $signed(s.yaw_angle);
    prate = $signed(s.pitch_rate);
    yrate = $signed(s.yaw_rate);
    refx  = $signed(s.reference_x);
    // A gap longer than one second freezes the integrators.
    dt = (s.elapsed > DT_ONE) ? 64'sd0 : $signed({32'b0, s.elapsed});
    pos_err_sum  = sat_integrate(pos_err_sum, scaled_product(px - refx, dt, DT_FRAC));
    head_err_sum = sat_integrate(head_err_sum, scaled_product(yaw, dt, DT_FRAC));
    balance = scaled_product(pos_err_sum, gains[lqrbt_pkg::GI_POS_INTEGRAL], FRAC)
            + scaled_product(px, gains[lqrbt_pkg::GI_POSITION], FRAC)
            + scaled_product(vx, gains[lqrbt_pkg::GI_VELOCITY], FRAC)
            + scaled_product(pitch, gains[lqrbt_pkg::GI_TILT], FRAC)
            + scaled_product(prate, gains[lqrbt_pkg::GI_TILT_RATE], FRAC);
    heading = scaled_product(yaw, gains[lqrbt_pkg::GI_HEADING], FRAC)
            + scaled_product(yrate, gains[lqrbt_pkg::GI_HEADING_RATE], FRAC);
    // The right wheel sees the heading-integral gain with its sign flipped.
    g_hi  = $signed(gains[lqrbt_pkg::GI_HEADING_INTEGRAL]);
    left  = -(balance + heading + scaled_product(head_err_sum, g_hi, FRAC));
    right = -(balance + heading + scaled_product(head_err_sum, -g_hi, FRAC));
    c.left  = clamp_torque(left);
    c.right = clamp_torque(right);
    return c;
  endfunction

  function automatic lqrbt_pkg::imu_item_t make_sample(
      input logic signed [31:0] px, vx, pitch, yaw,
      input logic signed [31:0] prate, yrate, refx,
      input logic [31:0] el);
    lqrbt_pkg::imu_item_t s;
    s.pos_x       = px;
    s.vel_x       = vx;
    s.pitch_angle = pitch;
    s.yaw_angle   = yaw;
    s.pitch_rate  = prate;
    s.yaw_rate    = yrate;
    s.reference_x = refx;
    s.elapsed     = el;
    return s;
  endfunction

  // Mostly modest values so the torques do not always saturate.
  function automatic logic signed [31:0] rand_field();
    logic signed [19:0] s20;
    logic signed [23:0] s24;
    s20 = $urandom();
    s24 = $urandom();
    case ($urandom_range(0, 7))
      0, 1:    return $urandom();
      2:       return $urandom_range(0, 1) ? FIELD_MAX : FIELD_MIN;
      3, 4, 5: return s20;
      default: return s24;
    endcase
  endfunction

  function automatic logic [31:0] rand_elapsed();
    case ($urandom_range(0, 7))
      0, 1, 7: return $urandom_range(0, DT_ONE);
      2:       return $urandom_range(0, 4095);
      3:       return DT_ONE;
      4:       return 32'd0;
      5:       return DT_ONE + $urandom_range(1, 1000);
      default: return $urandom();
    endcase
  endfunction

  function automatic logic signed [31:0] rand_gain();
    logic signed [23:0] s24;
    logic signed [27:0] s28;
    s24 = $urandom();
    s28 = $urandom();
    case ($urandom_range(0, 5))
      0:       return $urandom();
      1, 2, 3: return s24;
      4:       return $urandom_range(0, 1) ? FIELD_MAX : FIELD_MIN;
      default: return s28;
    endcase
  endfunction

  function automatic lqrbt_pkg::imu_item_t rand_sample();
    return make_sample(rand_field(), rand_field(), rand_field(), rand_field(),
                       rand_field(), rand_field(), rand_field(), rand_elapsed());
  endfunction

  // Writes all gain registers on consecutive cycles; only called while idle.
  task automatic set_gains(input gain_set_t g);
    lqrbt_pkg::gain_idx_t gi;
    gi = gi.first();
    do begin
      cfg_we    <= 1'b1;
      cfg_index <= gi;
      cfg_data  <= g[gi];
      @(posedge clk);
      gains[gi] = g[gi];
      gi = gi.next();
    end while (gi != gi.first());
    cfg_we <= 1'b0;
  endtask

  // Random bursts and gaps on the input side.
  task automatic pace_sender();
    int gap;
    if (steady_stream) begin
      return;
    end
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    burst_left = $urandom_range(0, 24);
    case ($urandom_range(0, 3))
      0:       gap = 0;
      1, 2:    gap = $urandom_range(1, 8);
      default: gap = $urandom_range(9, 45);
    endcase
    if (gap > 0) begin
      imu.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Offers one sample and records its prediction once the transfer happens.
  task automatic send_sample(input lqrbt_pkg::imu_item_t s);
    imu.valid       <= 1'b1;
    imu.pos_x       <= s.pos_x;
    imu.vel_x       <= s.vel_x;
    imu.pitch_angle <= s.pitch_angle;
    imu.yaw_angle   <= s.yaw_angle;
    imu.pitch_rate  <= s.pitch_rate;
    imu.yaw_rate    <= s.yaw_rate;
    imu.reference_x <= s.reference_x;
    imu.elapsed     <= s.elapsed;
    do @(posedge clk); while (!imu.ready);
    pending_cmds.push_back(predict_cmd(s));
    pace_sender();
  endtask

  // Stops offering and waits until every predicted torque pair has come back.
  task automatic wait_for_all_cmds();
    imu.valid <= 1'b0;
    while (pending_cmds.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Output side: ready pattern of its own, plus a long hold-off on request.
  initial begin
    int mode;
    int mode_left;
    int period;
    int on_len;
    int phase;
    mode = 0;
    mode_left = 0;
    period = 1;
    on_len = 1;
    phase = 0;
    cmd.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst) begin
        cmd.ready <= 1'b0;
      end else if (hold_cycles > 0) begin
        hold_cycles--;
        cmd.ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 3);
          mode_left = $urandom_range(10, 300);
          period    = $urandom_range(2, 23);
          on_len    = $urandom_range(1, period - 1);
          phase     = 0;
        end
        mode_left--;
        phase = (phase + 1) % period;
        case (mode)
          0:       cmd.ready <= 1'b1;
          1:       cmd.ready <= ($urandom_range(0, 9) < 7);
          2:       cmd.ready <= (phase < on_len);
          default: cmd.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Compares each transferred torque pair with the oldest prediction.
  initial begin
    wheel_cmd_t want;
    forever begin
      @(posedge clk);
      if (!rst && cmd.valid && cmd.ready) begin
        if (pending_cmds.size() == 0) begin
          failures++;
          if (failures <= 10) begin
            $display("unexpected torque pair: left %0d right %0d",
                     cmd.torque_left, cmd.torque_right);
          end
        end else begin
          want = pending_cmds.pop_front();
          if (cmd.torque_left !== want.left || cmd.torque_right !== want.right) begin
            failures++;
            if (failures <= 10) begin
              $display("torque mismatch: expected left %0d right %0d, got left %0d right %0d",
                       want.left, want.right, cmd.torque_left, cmd.torque_right);
            end
          end
        end
      end
    end
  end

  // Corner samples at power-on gains: zero, extremes, exact and long gaps, rounding.
  task automatic test_directed_corners();
    send_sample(make_sample(0, 0, 0, 0, 0, 0, 0, 32'd0));
    send_sample(make_sample(FIELD_MAX, FIELD_MAX, FIELD_MAX, FIELD_MAX,
                            FIELD_MAX, FIELD_MAX, FIELD_MAX, DT_ONE));
    send_sample(make_sample(FIELD_MIN, FIELD_MIN, FIELD_MIN, FIELD_MIN,
                            FIELD_MIN, FIELD_MIN, FIELD_MIN, DT_ONE));
    // Largest and smallest position error over exactly one second.
    send_sample(make_sample(FIELD_MAX, 0, 0, FIELD_MAX, 0, 0, FIELD_MIN, DT_ONE));
    send_sample(make_sample(FIELD_MIN, 0, 0, FIELD_MIN, 0, 0, FIELD_MAX, DT_ONE));
    // Gaps just above one second and at the top of the range hold the integrators.
    send_sample(make_sample(32'sd65536, 32'sd1000, -32'sd2000, 32'sd30000,
                            32'sd5, -32'sd7, -32'sd65536, DT_ONE + 32'd1));
    send_sample(make_sample(FIELD_MAX, FIELD_MIN, FIELD_MAX, FIELD_MIN,
                            FIELD_MAX, FIELD_MIN, FIELD_MIN, 32'hffff_ffff));
    // Tiny negative increments round toward minus infinity.
    send_sample(make_sample(-32'sd1, 0, 0, -32'sd1, 0, 0, 0, 32'd1));
    send_sample(make_sample(32'sd1, -32'sd1, 32'sd1, -32'sd3, 32'sd1, -32'sd1, 32'sd2,
                            DT_ONE - 32'd1));
    send_sample(make_sample(-32'sd123456, 32'sd654321, -32'sd98765, 32'sd43210,
                            -32'sd11111, 32'sd22222, 32'sd777777, 32'd167772));
    wait_for_all_cmds();
  endtask

  // Every gain at its largest, at its smallest, then all zero.
  task automatic test_gain_extremes();
    gain_set_t g;
    foreach (g[i]) g[i] = FIELD_MAX;
    set_gains(g);
    send_sample(make_sample(FIELD_MAX, FIELD_MAX, FIELD_MAX, FIELD_MAX,
                            FIELD_MAX, FIELD_MAX, FIELD_MIN, DT_ONE));
    send_sample(make_sample(FIELD_MIN, FIELD_MIN, FIELD_MIN, FIELD_MIN,
                            FIELD_MIN, FIELD_MIN, FIELD_MAX, DT_ONE));
    send_sample(make_sample(32'sd65536, -32'sd65536, 32'sd3, -32'sd3,
                            32'sd100, -32'sd100, 0, 32'd4096));
    wait_for_all_cmds();
    // The smallest heading-integral gain makes its right-wheel negation 2^31.
    foreach (g[i]) g[i] = FIELD_MIN;
    set_gains(g);
    send_sample(make_sample(FIELD_MAX, FIELD_MAX, FIELD_MAX, FIELD_MAX,
                            FIELD_MAX, FIELD_MAX, FIELD_MIN, DT_ONE));
    send_sample(make_sample(FIELD_MIN, FIELD_MIN, FIELD_MIN, FIELD_MIN,
                            FIELD_MIN, FIELD_MIN, FIELD_MAX, DT_ONE));
    send_sample(make_sample(-32'sd65536, 32'sd65536, -32'sd3, 32'sd3,
                            -32'sd100, 32'sd100, 0, 32'd4096));
    wait_for_all_cmds();
    foreach (g[i]) g[i] = 0;
    set_gains(g);
    send_sample(rand_sample());
    wait_for_all_cmds();
  endtask

  // Random samples under a series of random gain settings.
  task automatic test_random_gain_sweep();
    gain_set_t g;
    for (int phase = 0; phase < 6; phase++) begin
      if (phase == 0) begin
        g = POWER_ON_GAINS;
      end else begin
        foreach (g[i]) g[i] = rand_gain();
      end
      set_gains(g);
      repeat (200) send_sample(rand_sample());
      wait_for_all_cmds();
    end
  endtask

  // Receiver holds off for a long stretch while the sender keeps offering samples.
  task automatic test_output_backpressure();
    hold_cycles = 600;
    steady_stream = 1'b1;
    repeat (30) send_sample(rand_sample());
    steady_stream = 1'b0;
    wait_for_all_cmds();
    repeat (20) send_sample(rand_sample());
    wait_for_all_cmds();
  endtask

  // Sustained largest position error: integrators climb by about 2^32 (position)
  // and 2^31 (heading) per sample; the integral terms alone saturate both torques.
  task automatic test_integrator_windup();
    gain_set_t g;
    foreach (g[i]) g[i] = rand_gain();
    g[lqrbt_pkg::GI_POS_INTEGRAL]     = FIELD_MIN;
    g[lqrbt_pkg::GI_HEADING_INTEGRAL] = FIELD_MAX;
    set_gains(g);
    steady_stream = 1'b1;
    repeat (WINDUP_ITEMS) begin
      send_sample(make_sample(FIELD_MAX, rand_field(), rand_field(), FIELD_MAX,
                              rand_field(), rand_field(), FIELD_MIN, DT_ONE));
    end
    steady_stream = 1'b0;
    repeat (60) send_sample(rand_sample());
    wait_for_all_cmds();
  endtask

  // Sequence of tests and the final verdict.
  initial begin
    rst             = 1'b1;
    cfg_we          = 1'b0;
    cfg_index       = '0;
    cfg_data        = '0;
    imu.valid       = 1'b0;
    imu.pos_x       = '0;
    imu.vel_x       = '0;
    imu.pitch_angle = '0;
    imu.yaw_angle   = '0;
    imu.pitch_rate  = '0;
    imu.yaw_rate    = '0;
    imu.reference_x = '0;
    imu.elapsed     = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    test_directed_corners();
    test_gain_extremes();
    test_random_gain_sweep();
    test_output_backpressure();
    test_integrator_windup();

    wait_for_all_cmds();
    if (failures == 0 && pending_cmds.size() == 0) begin
      $display("lqr_balance_torque test passed");
    end else begin
      $display("lqr_balance_torque test failed");
    end
    $finish;
  end

endmodule

>>> lqr_balance_torque.f
src/lqrbt_pkg.sv
src/lqrbt_imu_if.sv
src/lqrbt_cmd_if.sv
src/lqrbt_sequencer.sv
src/lqrbt_datapath.sv
src/lqr_balance_torque.sv
tb/tb_top.sv
